// ===== src/odometry_motion_decompose_macros.svh =====
// Assertion macros for the odometry motion decomposition block.
`ifndef ODOMETRY_MOTION_DECOMPOSE_MACROS_SVH
`define ODOMETRY_MOTION_DECOMPOSE_MACROS_SVH
// Implication that must hold at every clock edge outside reset.
`define OMD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication outside reset.
`define OMD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== src/omd_pkg.sv =====
// Package with constants, types and helpers of the odometry motion decomposition block.
package omd_pkg;
	localparam int CordicSteps = 16;
	localparam logic signed [20:0] PiQ = 21'sd205887;
	localparam logic signed [20:0] TwoPiQ = 21'sd411775;
	localparam logic signed [20:0] HalfPiQ = 21'sd102944;
	localparam logic [31:0] TransMax = 32'h7fff_ffff;
	localparam logic [15:0] GainReset = 16'd655;
	localparam logic [0:0] RegTurn = 1'b0;
	localparam logic [0:0] RegTravel = 1'b1;
	localparam logic [1:0] RootMag = 2'd0;
	localparam logic [1:0] RootTurn1 = 2'd1;
	localparam logic [1:0] RootTravel = 2'd2;
	localparam logic [1:0] RootTurn2 = 2'd3;
	localparam int InW = 152;
	localparam int OutW = 208;

	typedef struct packed {
		logic start;
		logic cordic_step;
		logic root_step;
		logic [1:0] root_sel;
		logic root_load;
	} cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic root_done;
	} sts_t;

	function automatic logic signed [20:0] atan_entry(input logic [4:0] i);
		logic signed [20:0] r;
		case (i)
			5'd0: r = 21'sd51472;
			5'd1: r = 21'sd30386;
			5'd2: r = 21'sd16055;
			5'd3: r = 21'sd8150;
			5'd4: r = 21'sd4091;
			5'd5: r = 21'sd2047;
			5'd6: r = 21'sd1024;
			5'd7: r = 21'sd512;
			5'd8: r = 21'sd256;
			5'd9: r = 21'sd128;
			5'd10: r = 21'sd64;
			5'd11: r = 21'sd32;
			5'd12: r = 21'sd16;
			5'd13: r = 21'sd8;
			5'd14: r = 21'sd4;
			5'd15: r = 21'sd2;
			5'd16: r = 21'sd1;
			default: r = 21'sd0;
		endcase
		return r;
	endfunction

	// Reduces an angle within pi plus three full turns of zero into [-pi, pi].
	function automatic logic signed [20:0] wrap(input logic signed [22:0] a);
		logic signed [22:0] m;
		m = a;
		if (m > 23'(PiQ)) m = m - 23'(TwoPiQ);
		if (m > 23'(PiQ)) m = m - 23'(TwoPiQ);
		if (m > 23'(PiQ)) m = m - 23'(TwoPiQ);
		if (m < -23'(PiQ)) m = m + 23'(TwoPiQ);
		if (m < -23'(PiQ)) m = m + 23'(TwoPiQ);
		if (m < -23'(PiQ)) m = m + 23'(TwoPiQ);
		return m[20:0];
	endfunction
endpackage

// ===== src/omd_ctrl.sv =====
// Controller state machine that sequences the CORDIC and the square-root passes.
module omd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_fire,
	input  omd_pkg::sts_t    sts,
	output omd_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             out_valid
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StCordic = 3'd1;
	localparam logic [2:0] StRootLoad = 3'd2;
	localparam logic [2:0] StRoot = 3'd3;
	localparam logic [2:0] StOut = 3'd4;

	logic [2:0] state_q;
	logic [1:0] sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			sel_q <= omd_pkg::RootMag;
		end else begin
			unique case (state_q)
				StIdle: if (in_fire) state_q <= StCordic;
				StCordic: if (sts.cordic_done) begin
					state_q <= StRootLoad;
					sel_q <= omd_pkg::RootMag;
				end
				StRootLoad: state_q <= StRoot;
				StRoot: if (sts.root_done) begin
					if (sel_q == omd_pkg::RootTurn2) state_q <= StOut;
					else begin
						sel_q <= sel_q + 2'd1;
						state_q <= StRootLoad;
					end
				end
				StOut: if (out_fire) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	always_comb begin
		cmd.start = in_fire;
		cmd.cordic_step = (state_q == StCordic);
		cmd.root_load = (state_q == StRootLoad);
		cmd.root_step = (state_q == StRoot);
		cmd.root_sel = sel_q;
	end
	assign busy = (state_q != StIdle);
	assign out_valid = (state_q == StOut);
endmodule

// ===== src/omd_datapath.sv =====
// Datapath with pose registers, a CORDIC iteration and a shared bit-pair square root.
module omd_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  omd_pkg::cmd_t            cmd,
	output omd_pkg::sts_t            sts,
	input  logic [omd_pkg::InW-1:0]  in_word,
	input  logic [15:0]              turn_gain,
	input  logic [15:0]              travel_gain,
	output logic [omd_pkg::OutW-1:0] out_word
);
	logic have_q;
	logic signed [31:0] px_q, py_q;
	logic signed [19:0] ph_q;
	logic signed [19:0] oh_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [20:0] dh_q;
	logic [62:0] t_q;
	logic signed [58:0] cx_q, cy_q;
	logic signed [20:0] z_q;
	logic [4:0] it_q;
	logic zero_q;
	logic [63:0] sq_q;
	logic [1:0] sqi_q;
	logic [31:0] mag_q;
	logic sat_q;
	logic signed [20:0] w1_q, r1_q, r2_q;
	logic bwd_q;
	logic [63:0] rv_q, rr_q;
	logic [5:0] rk_q;
	logic [23:0] s1_q, s2_q, s3_q;
	logic moved_q;

	logic signed [31:0] ix, iy;
	logic signed [19:0] ih;
	logic signed [32:0] ndx, ndy;
	logic [32:0] adx, ady;
	logic signed [58:0] xs, ys;
	logic signed [22:0] a1;
	logic signed [20:0] mir;
	logic mir_en;
	logic [31:0] ab;
	logic [63:0] sqterm;
	logic [63:0] bitv, trial, rnext;
	logic [31:0] a1abs, a2abs;
	logic [15:0] mul_a;
	logic [31:0] mul_b;
	logic [47:0] prod;
	logic [31:0] magf;
	logic [31:0] trans;

	assign ix = in_word[31:0];
	assign iy = in_word[63:32];
	assign ih = in_word[83:64];
	assign ndx = have_q ? (33'(ix) - 33'(px_q)) : 33'sd0;
	assign ndy = have_q ? (33'(iy) - 33'(py_q)) : 33'sd0;
	assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign ab = (sqi_q[0] ? ady[31:0] : adx[31:0]);
	assign sqterm = 64'(ab) * 64'(ab);

	// The zero vector has an arctangent of zero.
	assign a1 = (zero_q ? 23'sd0 : 23'(z_q)) - 23'(oh_q);
	assign mir_en = (w1_q > omd_pkg::HalfPiQ) || (w1_q < -omd_pkg::HalfPiQ);
	assign mir = mir_en ? omd_pkg::wrap(23'(omd_pkg::PiQ) - 23'(w1_q)) : w1_q;
	assign a1abs = r1_q[20] ? 32'(-r1_q) : 32'(r1_q);
	assign a2abs = r2_q[20] ? 32'(-r2_q) : 32'(r2_q);
	assign magf = (sat_q || (mag_q > omd_pkg::TransMax)) ? omd_pkg::TransMax : mag_q;

	always_comb begin
		case (cmd.root_sel)
			omd_pkg::RootTurn1: begin
				mul_a = turn_gain;
				mul_b = a1abs;
			end
			omd_pkg::RootTravel: begin
				mul_a = travel_gain;
				mul_b = magf;
			end
			default: begin
				mul_a = turn_gain;
				mul_b = a2abs;
			end
		endcase
	end
	assign prod = 48'(mul_a) * 48'(mul_b);

	assign bitv = 64'd1 << {rk_q, 1'b0};
	assign trial = rr_q + bitv;
	assign rnext = (rv_q >= trial) ? ((rr_q >> 1) + bitv) : (rr_q >> 1);
	assign sts.cordic_done = (it_q == 5'(omd_pkg::CordicSteps - 1)) && sqi_q == 2'd2;
	assign sts.root_done = (rk_q == 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			px_q <= '0;
			py_q <= '0;
			ph_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			s3_q <= '0;
		end else begin
			if (cmd.start) begin
				have_q <= 1'b1;
				px_q <= ix;
				py_q <= iy;
				ph_q <= ih;
			end
			if (cmd.root_step && sts.root_done && moved_q) begin
				case (cmd.root_sel)
					omd_pkg::RootTurn1: s1_q <= 24'(rnext);
					omd_pkg::RootTravel: s2_q <= 24'(rnext);
					omd_pkg::RootTurn2: s3_q <= 24'(rnext);
					default: ;
				endcase
			end
		end
	end

	// Square roots in order: travel magnitude, first turn, travel and second turn deviations.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dx_q <= ndx;
			dy_q <= ndy;
			dh_q <= have_q ? (21'(ih) - 21'(ph_q)) : 21'sd0;
			oh_q <= have_q ? ph_q : ih;
			t_q <= in_word[146:84];
			it_q <= '0;
			sqi_q <= 2'd0;
			sq_q <= '0;
		end else if (cmd.cordic_step) begin
			if (sqi_q != 2'd2) begin
				sq_q <= sq_q + sqterm;
				sqi_q <= sqi_q + 2'd1;
				sat_q <= adx[32] | adx[31] | ady[32] | ady[31];
				zero_q <= (dx_q == 33'sd0) && (dy_q == 33'sd0);
				moved_q <= (dx_q != 33'sd0) || (dy_q != 33'sd0) || (dh_q != 21'sd0);
				if (dx_q[32]) begin
					cx_q <= -(59'(dx_q) <<< 24);
					cy_q <= -(59'(dy_q) <<< 24);
					z_q <= dy_q[32] ? -omd_pkg::PiQ : omd_pkg::PiQ;
				end else begin
					cx_q <= 59'(dx_q) <<< 24;
					cy_q <= 59'(dy_q) <<< 24;
					z_q <= '0;
				end
			end else begin
				if (!cy_q[58]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q <= z_q + omd_pkg::atan_entry(it_q);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q <= z_q - omd_pkg::atan_entry(it_q);
				end
				it_q <= it_q + 5'd1;
			end
		end else if (cmd.root_load) begin
			if (cmd.root_sel == omd_pkg::RootMag) w1_q <= omd_pkg::wrap(a1);
			else if (cmd.root_sel == omd_pkg::RootTurn1)
				r2_q <= omd_pkg::wrap(23'(dh_q) - 23'(r1_q));
			rv_q <= (cmd.root_sel == omd_pkg::RootMag) ? sq_q : 64'(prod);
			rr_q <= '0;
			rk_q <= 6'd31;
		end else if (cmd.root_step) begin
			if (rv_q >= trial) rv_q <= rv_q - trial;
			rr_q <= rnext;
			if (rk_q != 6'd0) rk_q <= rk_q - 6'd1;
			if (cmd.root_sel == omd_pkg::RootMag) begin
				r1_q <= mir;
				bwd_q <= mir_en;
				if (sts.root_done) mag_q <= 32'(rnext);
			end
		end
	end

	assign trans = bwd_q ? (-magf) : magf;
	assign out_word = {2'b00, t_q, s3_q, s2_q, s1_q, r2_q[18:0], r1_q[18:0], trans, moved_q};
endmodule

// ===== src/odometry_motion_decompose.sv =====
// Top level of the odometry motion decomposition block.
// The result word becomes valid after the CORDIC pass (squaring of both step components, then
// sixteen iterations) and four square-root passes.
// One word is in flight at a time; the next word is taken once the result is taken.
// Reset (arst_n low) clears the previous pose and held deviations and sets both gains to 655.
module odometry_motion_decompose (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [151:0] s_axis_tdata, // odom_x, odom_y, odom_heading, odom_time
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [207:0] m_axis_tdata, // moved, translation, first_turn, second_turn,
	                                   // first_turn_sigma, travel_sigma, second_turn_sigma, stamp
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);
	omd_pkg::cmd_t cmd;
	omd_pkg::sts_t sts;
	logic busy, in_fire, out_fire;
	logic [15:0] turn_q, travel_q;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_q <= omd_pkg::GainReset;
			travel_q <= omd_pkg::GainReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				omd_pkg::RegTurn: turn_q <= cfg_data;
				default: travel_q <= cfg_data;
			endcase
		end
	end

	omd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
	);

	omd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_word(s_axis_tdata),
		.turn_gain(turn_q), .travel_gain(travel_q), .out_word(m_axis_tdata)
	);
endmodule

// ===== src/omd_checker.sv =====
// Port checker of the odometry motion decomposition block and its bind.
`include "odometry_motion_decompose_macros.svh"
module omd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [207:0] m_axis_tdata
);
	`OMD_ASSERT_IMP(a_excl, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`OMD_ASSERT_NXT(a_start, clk, arst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
	`OMD_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`OMD_ASSERT_NXT(a_data, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`OMD_ASSERT_IMP(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[207:206] == 2'b00)
endmodule

bind odometry_motion_decompose omd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
